/* rtl/fiob_pkg.sv */
// Package for the framed I/O board command responder.
// Holds framing constants, command codes, the queue entry type and the reply tables.
// No dependencies.
package fiob_pkg;

    // Framing
    localparam logic [7:0] SOF_BYTE  = 8'hAA;
    localparam logic [7:0] ESC_BYTE  = 8'hFF;
    localparam logic [7:0] MAX_LEN   = 8'h7F;
    localparam int unsigned HEAD_DEPTH = 6;

    // Queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int unsigned APB_AW = 3;
    localparam logic [APB_AW-1:0] ADDR_SD_MODE = 3'd0;

    // Command codes
    localparam logic [7:0] CMD_VERSION  = 8'h01;
    localparam logic [7:0] CMD_STAT_05  = 8'h05;
    localparam logic [7:0] CMD_LAMP     = 8'h24;
    localparam logic [7:0] CMD_PLUG     = 8'h25;
    localparam logic [7:0] CMD_CABINET  = 8'h27;
    localparam logic [7:0] CMD_STAT_29  = 8'h29;
    localparam logic [7:0] CMD_STAT_2B  = 8'h2B;
    localparam logic [7:0] CMD_STAT_2F  = 8'h2F;
    localparam logic [7:0] CMD_STAT_31  = 8'h31;
    localparam logic [7:0] CMD_STAT_32  = 8'h32;
    localparam logic [7:0] CMD_PORT     = 8'h38;
    localparam logic [7:0] CMD_RMT_WR   = 8'h3A;
    localparam logic [7:0] CMD_RMT_RD   = 8'h3B;

    // Plug request flag in body byte 2 that selects the black table
    localparam logic [7:0] PLUG_BLACK_MASK = 8'h10;

    // Reply shapes
    typedef enum logic [2:0] {
        K_VERSION = 3'd0,
        K_ZERO2   = 3'd1,
        K_PLUG    = 3'd2,
        K_CABINET = 3'd3,
        K_ZERO3   = 3'd4,
        K_ZERO7   = 3'd5,
        K_ARG3    = 3'd6
    } t_kind;

    typedef logic [5:0] t_idx;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  arg;
        logic [10:0] lamp;
    } t_desc;

    function automatic t_idx reply_len(input t_kind kind);
        t_idx len;
        case (kind)
            K_VERSION: len = 6'd8;
            K_ZERO2:   len = 6'd2;
            K_PLUG:    len = 6'd43;
            K_CABINET: len = 6'd2;
            K_ZERO3:   len = 6'd3;
            K_ZERO7:   len = 6'd7;
            K_ARG3:    len = 6'd3;
            default:   len = 6'd2;
        endcase
        return len;
    endfunction

    // Security plug tables, 40 entries each, position 0..39.
    function automatic logic [7:0] plug_byte(input logic black, input t_idx pos);
        logic [7:0] b;
        b = 8'h00;
        if (pos < 6'd8) begin
            b = 8'hF0 | {5'd0, pos[2:0]};
        end else begin
            case (pos)
                6'd8:  b = black ? 8'hBE : 8'hC3;
                6'd9:  b = black ? 8'hB5 : 8'hD4;
                6'd10: b = black ? 8'hB2 : 8'h45;
                6'd11: b = black ? 8'hAC : 8'hE8;
                6'd12: b = black ? 8'h16 : 8'h7C;
                6'd13: b = black ? 8'h8C : 8'h17;
                6'd14: b = black ? 8'hE7 : 8'h20;
                6'd15: b = black ? 8'hA8 : 8'h08;
                6'd16: b = black ? 8'h92 : 8'h82;
                6'd17: b = black ? 8'hB8 : 8'h20;
                6'd18: b = black ? 8'h1A : 8'h08;
                6'd19: b = black ? 8'h86 : 8'h82;
                6'd39: b = black ? 8'hF7 : 8'h1B;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    // Unescaped payload byte at position idx of a reply.
    function automatic logic [7:0] payload_byte(input t_kind kind, input logic [7:0] arg,
                                                input t_idx idx);
        logic [7:0] b;
        b = 8'h00;
        case (kind)
            K_VERSION: begin
                case (idx)
                    6'd2:    b = 8'h4A;
                    6'd3:    b = 8'h44;
                    6'd4:    b = 8'h58;
                    default: b = 8'h00;
                endcase
            end
            K_PLUG: begin
                if (idx == 6'd2) begin
                    b = 8'h01;
                end else if (idx >= 6'd3) begin
                    b = plug_byte(arg[0], idx - 6'd3);
                end
            end
            K_CABINET: begin
                if (idx == 6'd1) begin
                    b = arg;
                end
            end
            K_ARG3: begin
                if (idx == 6'd2) begin
                    b = arg;
                end
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/framed_io_board_command_responder.sv */
// Top level of the framed I/O board command responder.
// Holds the configuration register and connects front end, queue and reply generator.
// Depends on fiob_pkg, fiob_front, fiob_queue and fiob_back.
//
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+------------------------------------
//   rx       | in        | i_rx_valid / o_rx_ready   | i_rx_byte, i_rx_end
//   tx       | out       | o_tx_valid / i_tx_ready   | o_tx_byte, o_tx_last, o_lamp_state
//   config   | in        | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// Host bytes are taken one per cycle while the descriptor queue has room.
// An answered frame is queued at the edge of its final byte, and its first reply byte is
// loaded into the output register when the generator is free; reply bytes, escape prefixes
// included, then leave one per cycle while i_tx_ready is high, with no gap between frames.
// Reset is synchronous and active low; it clears the frame state, the lamps and the mode.
// On a reply stall, o_rx_ready drops once four frames wait behind the one being sent.
module framed_io_board_command_responder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_rx_end,

    output logic                          o_tx_valid,
    input  logic                          i_tx_ready,
    output logic [7:0]                    o_tx_byte,
    output logic                          o_tx_last,
    output logic [10:0]                   o_lamp_state,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fiob_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Mode register: selects the older lamp mapping and cabinet type zero.
    logic r_sd_mode;

    logic            cfg_wr;
    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    logic            q_full;
    fiob_pkg::t_desc push_desc;
    fiob_pkg::t_desc head_desc;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_mode <= 1'b0;
        end else if (cfg_wr && paddr == fiob_pkg::ADDR_SD_MODE) begin
            r_sd_mode <= pwdata[0];
        end
    end

    assign prdata = (paddr == fiob_pkg::ADDR_SD_MODE) ? {31'd0, r_sd_mode} : 32'd0;

    // The front end unframes the host write and, on its final byte, decides whether
    // a reply is due. Answered frames become descriptors in the queue.
    fiob_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sd_mode  (r_sd_mode),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .i_rx_end   (i_rx_end),
        .o_rx_ready (o_rx_ready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_desc     (push_desc)
    );

    fiob_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .i_pop   (q_pop),
        .o_desc  (head_desc),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The reply generator walks each descriptor and emits the escaped frame, each
    // transaction carrying the lamp state as it stood after the answered write.
    fiob_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (!q_empty),
        .i_desc       (head_desc),
        .o_pop        (q_pop),
        .o_tx_valid   (o_tx_valid),
        .i_tx_ready   (i_tx_ready),
        .o_tx_byte    (o_tx_byte),
        .o_tx_last    (o_tx_last),
        .o_lamp_state (o_lamp_state)
    );

endmodule

/* rtl/fiob_front.sv */
// Front end: unframes host bytes, checks the frame and classifies the command.
// Pushes one reply descriptor per answered frame and owns the lamp register.
// Depends on fiob_pkg.
module fiob_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sd_mode,
    input  logic              i_rx_valid,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_rx_end,
    output logic              o_rx_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output fiob_pkg::t_desc   o_desc
);

    logic [7:0]  r_pos, n_pos;
    logic        r_esc, n_esc;
    logic        r_hdr_ok, n_hdr_ok;
    logic [6:0]  r_decl, n_decl;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_head [fiob_pkg::HEAD_DEPTH];
    logic [7:0]  n_head [fiob_pkg::HEAD_DEPTH];
    logic [10:0] r_lamp, n_lamp;

    logic        accept;
    logic        body_push;
    logic [7:0]  body_val;
    logic        frame_ok;
    logic        known;
    logic [10:0] lamp_new;
    logic [7:0]  lb;
    fiob_pkg::t_desc desc;

    assign accept     = i_rx_valid && !i_q_full;
    assign o_rx_ready = !i_q_full;

    always_comb begin
        n_pos     = r_pos;
        n_esc     = r_esc;
        n_hdr_ok  = r_hdr_ok;
        n_decl    = r_decl;
        n_cnt     = r_cnt;
        body_push = 1'b0;
        body_val  = i_rx_byte;
        for (int i = 0; i < fiob_pkg::HEAD_DEPTH; i++) begin
            n_head[i] = r_head[i];
        end

        if (r_pos == 8'd0) begin
            n_hdr_ok = (i_rx_byte == fiob_pkg::SOF_BYTE);
        end else if (r_pos == 8'd1) begin
            if (i_rx_byte > fiob_pkg::MAX_LEN) begin
                n_hdr_ok = 1'b0;
            end
            n_decl = i_rx_byte[6:0];
        end else if (r_esc) begin
            n_esc     = 1'b0;
            body_push = 1'b1;
            body_val  = ~i_rx_byte;
        end else if (i_rx_byte == fiob_pkg::ESC_BYTE && !i_rx_end) begin
            n_esc = 1'b1;
        end else begin
            body_push = 1'b1;
        end

        // Decoded body byte 0 is not kept; bytes 1..6 land in the head store.
        if (body_push) begin
            for (int i = 0; i < fiob_pkg::HEAD_DEPTH; i++) begin
                if (r_cnt == 8'(i + 1)) begin
                    n_head[i] = body_val;
                end
            end
            if (r_cnt != 8'hFF) begin
                n_cnt = r_cnt + 8'd1;
            end
        end
        if (r_pos != 8'hFF) begin
            n_pos = r_pos + 8'd1;
        end
    end

    // Frame check and command classification on the updated frame state.
    always_comb begin
        frame_ok = (n_pos >= 8'd2) && n_hdr_ok && (n_cnt == {1'b0, n_decl})
                   && (n_cnt >= 8'd2);
        lb       = n_head[5];
        lamp_new = r_lamp;
        known    = 1'b1;
        desc.kind = fiob_pkg::K_ZERO2;
        desc.arg  = 8'h00;

        case (n_head[0])
            fiob_pkg::CMD_VERSION: begin
                desc.kind = fiob_pkg::K_VERSION;
            end
            fiob_pkg::CMD_STAT_05, fiob_pkg::CMD_STAT_2B,
            fiob_pkg::CMD_STAT_2F, fiob_pkg::CMD_STAT_32: begin
                desc.kind = fiob_pkg::K_ZERO2;
            end
            fiob_pkg::CMD_LAMP: begin
                desc.kind = fiob_pkg::K_ZERO2;
                if (i_sd_mode) begin
                    lamp_new[4] = lb[0];
                    lamp_new[5] = lb[1];
                    lamp_new[6] = lb[6];
                    lamp_new[7] = lb[7];
                    lamp_new[8] = lb[4];
                    lamp_new[9] = lb[5];
                end else begin
                    lamp_new[3:0]  = lb[3:0];
                    lamp_new[9:6]  = lb[3:0];
                    lamp_new[10]   = lb[0];
                end
            end
            fiob_pkg::CMD_PLUG: begin
                desc.kind = fiob_pkg::K_PLUG;
                desc.arg  = {7'd0, (n_head[1] & fiob_pkg::PLUG_BLACK_MASK) != 8'h00};
            end
            fiob_pkg::CMD_CABINET: begin
                desc.kind = fiob_pkg::K_CABINET;
                desc.arg  = {7'd0, !i_sd_mode};
            end
            fiob_pkg::CMD_STAT_29, fiob_pkg::CMD_RMT_RD: begin
                desc.kind = fiob_pkg::K_ZERO3;
            end
            fiob_pkg::CMD_STAT_31: begin
                desc.kind = fiob_pkg::K_ZERO7;
            end
            fiob_pkg::CMD_PORT: begin
                desc.kind = fiob_pkg::K_ARG3;
                desc.arg  = (n_head[2] == 8'h00 || n_head[2] == 8'hFF) ? 8'h00 : 8'hFF;
            end
            fiob_pkg::CMD_RMT_WR: begin
                desc.kind = fiob_pkg::K_ARG3;
                desc.arg  = n_head[2];
            end
            default: begin
                known = 1'b0;
            end
        endcase
        desc.lamp = lamp_new;
    end

    assign o_push = accept && i_rx_end && frame_ok && known;
    assign o_desc = desc;
    assign n_lamp = o_push ? lamp_new : r_lamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_esc    <= 1'b0;
            r_hdr_ok <= 1'b0;
            r_decl   <= '0;
            r_cnt    <= '0;
            r_lamp   <= '0;
            for (int i = 0; i < fiob_pkg::HEAD_DEPTH; i++) begin
                r_head[i] <= '0;
            end
        end else if (accept) begin
            r_lamp <= n_lamp;
            if (i_rx_end) begin
                r_pos    <= '0;
                r_esc    <= 1'b0;
                r_hdr_ok <= 1'b0;
                r_decl   <= '0;
                r_cnt    <= '0;
                for (int i = 0; i < fiob_pkg::HEAD_DEPTH; i++) begin
                    r_head[i] <= '0;
                end
            end else begin
                r_pos    <= n_pos;
                r_esc    <= n_esc;
                r_hdr_ok <= n_hdr_ok;
                r_decl   <= n_decl;
                r_cnt    <= n_cnt;
                for (int i = 0; i < fiob_pkg::HEAD_DEPTH; i++) begin
                    r_head[i] <= n_head[i];
                end
            end
        end
    end

endmodule

/* rtl/fiob_queue.sv */
// Small descriptor queue between the front end and the reply generator.
// Register based, one push and one pop per cycle.
// Depends on fiob_pkg.
module fiob_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fiob_pkg::t_desc   i_desc,
    input  logic              i_pop,
    output fiob_pkg::t_desc   o_desc,
    output logic              o_empty,
    output logic              o_full
);

    fiob_pkg::t_desc r_mem [fiob_pkg::QDEPTH];
    logic [fiob_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [fiob_pkg::QCNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == fiob_pkg::QCNT_W'(fiob_pkg::QDEPTH));
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
`endif

endmodule

/* rtl/fiob_back.sv */
// Reply generator: a descriptor becomes an escaped frame, a byte per unstalled cycle.
// Drives the registered output stage of the reply channel.
// Depends on fiob_pkg.
module fiob_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  fiob_pkg::t_desc   i_desc,
    output logic              o_pop,
    output logic              o_tx_valid,
    input  logic              i_tx_ready,
    output logic [7:0]        o_tx_byte,
    output logic              o_tx_last,
    output logic [10:0]       o_lamp_state
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEN  = 4'b0010,
        S_DATA = 4'b0100,
        S_ESC  = 4'b1000
    } t_bstate;

    t_bstate          r_state, n_state;
    fiob_pkg::t_desc  r_desc, n_desc;
    fiob_pkg::t_idx   r_idx, n_idx;
    fiob_pkg::t_idx   r_len, n_len;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic [10:0]      r_out_lamp, n_out_lamp;

    logic             out_free;
    logic [7:0]       cur;
    logic             idx_last;

    assign out_free = !r_out_valid || i_tx_ready;
    assign cur      = fiob_pkg::payload_byte(r_desc.kind, r_desc.arg, r_idx);
    assign idx_last = (r_idx == r_len - 6'd1);

    always_comb begin
        n_state     = r_state;
        n_desc      = r_desc;
        n_idx       = r_idx;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_tx_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_lamp  = r_out_lamp;
        o_pop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (out_free && i_q_valid) begin
                    o_pop       = 1'b1;
                    n_desc      = i_desc;
                    n_len       = fiob_pkg::reply_len(i_desc.kind);
                    n_out_valid = 1'b1;
                    n_out_byte  = fiob_pkg::SOF_BYTE;
                    n_out_last  = 1'b0;
                    n_out_lamp  = i_desc.lamp;
                    n_state     = S_LEN;
                end
            end
            S_LEN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = {2'b00, r_len};
                    n_out_last  = (r_len == '0);
                    n_out_lamp  = r_desc.lamp;
                    n_idx       = '0;
                    n_state     = (r_len == '0) ? S_IDLE : S_DATA;
                end
            end
            S_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_lamp  = r_desc.lamp;
                    if (cur == fiob_pkg::SOF_BYTE || cur == fiob_pkg::ESC_BYTE) begin
                        n_out_byte = fiob_pkg::ESC_BYTE;
                        n_out_last = 1'b0;
                        n_state    = S_ESC;
                    end else begin
                        n_out_byte = cur;
                        n_out_last = idx_last;
                        n_idx      = r_idx + 6'd1;
                        n_state    = idx_last ? S_IDLE : S_DATA;
                    end
                end
            end
            S_ESC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_lamp  = r_desc.lamp;
                    n_out_byte  = ~cur;
                    n_out_last  = idx_last;
                    n_idx       = r_idx + 6'd1;
                    n_state     = idx_last ? S_IDLE : S_DATA;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc     <= n_desc;
        r_idx      <= n_idx;
        r_len      <= n_len;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_lamp <= n_out_lamp;
    end

    assign o_tx_valid   = r_out_valid;
    assign o_tx_byte    = r_out_byte;
    assign o_tx_last    = r_out_last;
    assign o_lamp_state = r_out_lamp;

`ifndef SYNTHESIS
    a_esc_prefix_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ESC) |-> (r_out_valid && r_out_byte == fiob_pkg::ESC_BYTE))
        else $error("escape state without escape prefix in output stage");

    a_pop_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_LEN && r_out_byte == fiob_pkg::SOF_BYTE))
        else $error("descriptor taken without starting a frame");
`endif

endmodule

/* tb/sv/tb_framed_io_board_command_responder.sv */
// Self-checking testbench for the framed I/O board command responder.
// Drives host writes and checks every reply byte against a cycle-free predictor.
// Depends on fiob_pkg and framed_io_board_command_responder.
module tb_framed_io_board_command_responder;

    // Run control. The cycle limit is far above the slowest legal run: every host byte
    // answered with a full plug reply, every reply byte stalled, plus the long hold-off.
    localparam int LIMIT_CYCLES  = 400000;
    // Cycles that cover a frame in flight through front end, queue and reply register.
    localparam int SETTLE_CYCLES = 32;
    // Percentage of cycles in which either side idles.
    localparam int IDLE_PCT      = 11;
    // Printed mismatch lines are capped; all of them are still counted.
    localparam int MAX_REPORTS   = 40;

    // One transaction on the reply channel as the predictor expects it.
    typedef struct packed {
        logic [7:0]  data;
        logic        is_last;
        logic [10:0] lamps;
    } t_reply_beat;

    // Security plug tables, indexed by table position 0..39.
    localparam logic [7:0] BLACK_PLUG [40] = '{
        8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
        8'hBE, 8'hB5, 8'hB2, 8'hAC, 8'h16, 8'h8C, 8'hE7, 8'hA8,
        8'h92, 8'hB8, 8'h1A, 8'h86,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hF7
    };
    localparam logic [7:0] WHITE_PLUG [40] = '{
        8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
        8'hC3, 8'hD4, 8'h45, 8'hE8, 8'h7C, 8'h17, 8'h20, 8'h08,
        8'h82, 8'h20, 8'h08, 8'h82,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h1B
    };

    localparam int N_KNOWN = 13;
    localparam logic [7:0] KNOWN_CMDS [N_KNOWN] = '{
        fiob_pkg::CMD_VERSION, fiob_pkg::CMD_STAT_05, fiob_pkg::CMD_LAMP,
        fiob_pkg::CMD_PLUG, fiob_pkg::CMD_CABINET, fiob_pkg::CMD_STAT_29,
        fiob_pkg::CMD_STAT_2B, fiob_pkg::CMD_STAT_2F, fiob_pkg::CMD_STAT_31,
        fiob_pkg::CMD_STAT_32, fiob_pkg::CMD_PORT, fiob_pkg::CMD_RMT_WR,
        fiob_pkg::CMD_RMT_RD
    };

    // Two lamp bytes for each mode, chosen so that kept and changed lamps both show.
    localparam logic [7:0] LAMP_PATTERNS [4] = '{
        8'hFF, 8'h36, 8'hA5, 8'h53
    };

    // Clock, reset and every block input start at known values.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_rx_valid = 1'b0;
    logic              o_rx_ready;
    logic [7:0]        i_rx_byte = 8'h00;
    logic              i_rx_end = 1'b0;
    logic              o_tx_valid;
    logic              i_tx_ready = 1'b0;
    logic [7:0]        o_tx_byte;
    logic              o_tx_last;
    logic [10:0]       o_lamp_state;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [fiob_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = 32'h0;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor state: the frame being parsed, the lamp register and the mode register.
    logic [7:0]  hw_pos = 8'h00;
    logic        hw_esc = 1'b0;
    logic        hw_hdr_ok = 1'b0;
    logic [6:0]  hw_len = 7'h00;
    logic [7:0]  hw_cnt = 8'h00;
    logic [7:0]  hw_head [fiob_pkg::HEAD_DEPTH] = '{default: 8'h00};
    logic [10:0] lamp_shadow = 11'h000;
    logic        mode_shadow = 1'b0;

    // Reply bytes still owed by the block, oldest first.
    t_reply_beat reply_beats [$];
    t_reply_beat beat_want;

    // Host write under construction: decoded body, then raw bytes with framing.
    logic [7:0] body_bytes [$];
    logic [7:0] host_bytes [$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  hold_left = 0;     // receiver hold-off, counted down by the receiver process
    logic no_idle = 1'b0;   // suppresses random idling on both channels

    framed_io_board_command_responder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .i_rx_end     (i_rx_end),
        .o_tx_valid   (o_tx_valid),
        .i_tx_ready   (i_tx_ready),
        .o_tx_byte    (o_tx_byte),
        .o_tx_last    (o_tx_last),
        .o_lamp_state (o_lamp_state),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run. A hang anywhere ends here as a failure.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    //------------------------------------------------------------------------------------
    // Small helpers
    //------------------------------------------------------------------------------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic void add_host_byte(input logic [7:0] b);
        host_bytes.insert(host_bytes.size(), b);
    endfunction

    function automatic void add_body_byte(input logic [7:0] b);
        body_bytes.insert(body_bytes.size(), b);
    endfunction

    //------------------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------------------

    // Forget the frame in progress; this happens after every host write.
    function automatic void frame_restart();
        hw_pos = 8'h00;
        hw_esc = 1'b0;
        hw_hdr_ok = 1'b0;
        hw_len = 7'h00;
        hw_cnt = 8'h00;
        foreach (hw_head[i]) hw_head[i] = 8'h00;
    endfunction

    // The first decoded body byte is counted but not kept; the next six are kept,
    // so the command lands in hw_head[0] and the lamp byte in hw_head[5].
    function automatic void take_body_byte(input logic [7:0] b);
        if (hw_cnt >= 8'd1 && hw_cnt <= 8'(fiob_pkg::HEAD_DEPTH))
            hw_head[hw_cnt - 8'd1] = b;
        if (hw_cnt != 8'hFF)
            hw_cnt++;
    endfunction

    function automatic void expect_beat(input logic [7:0] data, input logic is_last);
        t_reply_beat beat;
        beat.data = data;
        beat.is_last = is_last;
        beat.lamps = lamp_shadow;
        reply_beats.insert(reply_beats.size(), beat);
    endfunction

    // Work out the reply to a well-formed frame and queue its escaped bytes. The lamp
    // register is updated first, so every byte of a lamp reply carries the new lamps.
    function automatic void answer_command();
        logic [7:0] pl [43];
        logic [7:0] lb;
        logic [7:0] b;
        int         n;
        logic       known;
        foreach (pl[i]) pl[i] = 8'h00;
        known = 1'b1;
        n = 0;
        case (hw_head[0])
            fiob_pkg::CMD_VERSION: begin
                pl[2] = 8'h4A;
                pl[3] = 8'h44;
                pl[4] = 8'h58;
                n = 8;
            end
            fiob_pkg::CMD_STAT_05, fiob_pkg::CMD_STAT_2B, fiob_pkg::CMD_STAT_2F,
            fiob_pkg::CMD_STAT_32: begin
                n = 2;
            end
            fiob_pkg::CMD_LAMP: begin
                lb = hw_head[5];
                if (mode_shadow) begin
                    // Older cabinets: buttons and the four halogens, spots and neon keep.
                    lamp_shadow[4] = lb[0];
                    lamp_shadow[5] = lb[1];
                    lamp_shadow[6] = lb[6];
                    lamp_shadow[7] = lb[7];
                    lamp_shadow[8] = lb[4];
                    lamp_shadow[9] = lb[5];
                end else begin
                    // Newer cabinets: spots and halogens share bits 24..27, neon follows
                    // bit 24, buttons keep.
                    lamp_shadow[3:0] = lb[3:0];
                    lamp_shadow[9:6] = lb[3:0];
                    lamp_shadow[10] = lb[0];
                end
                n = 2;
            end
            fiob_pkg::CMD_PLUG: begin
                pl[2] = 8'h01;
                for (int i = 0; i < 40; i++)
                    pl[3 + i] = ((hw_head[1] & fiob_pkg::PLUG_BLACK_MASK) != 8'h00) ?
                                BLACK_PLUG[i] : WHITE_PLUG[i];
                n = 43;
            end
            fiob_pkg::CMD_CABINET: begin
                pl[1] = mode_shadow ? 8'h00 : 8'h01;
                n = 2;
            end
            fiob_pkg::CMD_STAT_29, fiob_pkg::CMD_RMT_RD: begin
                n = 3;
            end
            fiob_pkg::CMD_STAT_31: begin
                n = 7;
            end
            fiob_pkg::CMD_PORT: begin
                pl[2] = (hw_head[2] == 8'h00 || hw_head[2] == 8'hFF) ? 8'h00 : 8'hFF;
                n = 3;
            end
            fiob_pkg::CMD_RMT_WR: begin
                pl[2] = hw_head[2];
                n = 3;
            end
            default: known = 1'b0;
        endcase
        if (known) begin
            expect_beat(fiob_pkg::SOF_BYTE, 1'b0);
            expect_beat(n[7:0], n == 0);
            for (int i = 0; i < n; i++) begin
                b = pl[i];
                if (b == fiob_pkg::SOF_BYTE || b == fiob_pkg::ESC_BYTE) begin
                    expect_beat(fiob_pkg::ESC_BYTE, 1'b0);
                    b = ~b;
                end
                expect_beat(b, i == n - 1);
            end
        end
    endfunction

    // Advance the predictor by one accepted host byte.
    function automatic void model_host_byte(input logic [7:0] b, input logic is_end);
        if (hw_pos == 8'd0) begin
            hw_hdr_ok = (b == fiob_pkg::SOF_BYTE);
        end else if (hw_pos == 8'd1) begin
            if (b > fiob_pkg::MAX_LEN)
                hw_hdr_ok = 1'b0;
            hw_len = b[6:0];
        end else if (hw_esc) begin
            hw_esc = 1'b0;
            take_body_byte(~b);
        end else if (b == fiob_pkg::ESC_BYTE && !is_end) begin
            hw_esc = 1'b1;
        end else begin
            take_body_byte(b);
        end
        if (hw_pos != 8'hFF)
            hw_pos++;
        if (is_end) begin
            if (hw_pos >= 8'd2 && hw_hdr_ok && hw_cnt == {1'b0, hw_len} && hw_cnt >= 8'd2)
                answer_command();
            frame_restart();
        end
    endfunction

    //------------------------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch, %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Every reply transaction is compared field by field with the oldest expectation.
    // Outputs are read at the clock edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_tx_valid && i_tx_ready) begin
            if (reply_beats.size() == 0) begin
                report_mismatch("reply byte with none expected", {24'h0, o_tx_byte}, 32'h0);
            end else begin
                beat_want = reply_beats.pop_front();
                if (o_tx_byte !== beat_want.data)
                    report_mismatch("tx_byte", {24'h0, o_tx_byte}, {24'h0, beat_want.data});
                if (o_tx_last !== beat_want.is_last)
                    report_mismatch("tx_last", {31'h0, o_tx_last}, {31'h0, beat_want.is_last});
                if (o_lamp_state !== beat_want.lamps)
                    report_mismatch("lamp_state", {21'h0, o_lamp_state},
                                    {21'h0, beat_want.lamps});
            end
        end
    end

    // Receiver: a hold-off stretch wins over everything, otherwise random idling
    // unless the no-idle stretch is on.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_tx_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (no_idle) begin
            i_tx_ready <= 1'b1;
        end else begin
            i_tx_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    //------------------------------------------------------------------------------------
    // Host side and configuration port
    //------------------------------------------------------------------------------------

    // Offer one host byte and wait for its transaction. Valid stays high on return so
    // that a following byte goes out back to back; anything that lets time pass without
    // a new byte must lower it first.
    task automatic push_rx(input logic [7:0] b, input logic is_end);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        i_rx_end <= is_end;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        model_host_byte(b, is_end);
        items_sent++;
    endtask

    // Send host_bytes as one host write, the end flag on its final byte.
    task automatic send_host_write();
        for (int i = 0; i < host_bytes.size(); i++)
            push_rx(host_bytes[i], i == host_bytes.size() - 1);
    endtask

    // Frame body_bytes with the given length byte. Escapes are used for 0xFF and at
    // random for any other byte; a final 0xFF is sometimes left literal.
    task automatic send_frame_body(input logic [7:0] decl);
        logic [7:0] b;
        host_bytes.delete();
        add_host_byte(fiob_pkg::SOF_BYTE);
        add_host_byte(decl);
        for (int i = 0; i < body_bytes.size(); i++) begin
            b = body_bytes[i];
            if (i == body_bytes.size() - 1 && b == fiob_pkg::ESC_BYTE &&
                $urandom_range(1) == 0) begin
                add_host_byte(b);
            end else if (b == fiob_pkg::ESC_BYTE || $urandom_range(7) == 0) begin
                add_host_byte(fiob_pkg::ESC_BYTE);
                add_host_byte(~b);
            end else begin
                add_host_byte(b);
            end
        end
        send_host_write();
    endtask

    // Build a body of n bytes: command at byte 1, argument bytes at 2 and 3, the lamp
    // byte at 6, random filler elsewhere.
    task automatic fill_body(input logic [7:0] cmd, input int n, input logic [7:0] arg2,
                             input logic [7:0] arg3, input logic [7:0] lamp_byte);
        body_bytes.delete();
        for (int i = 0; i < n; i++) begin
            case (i)
                1:       add_body_byte(cmd);
                2:       add_body_byte(arg2);
                3:       add_body_byte(arg3);
                6:       add_body_byte(lamp_byte);
                default: add_body_byte(rand_byte());
            endcase
        end
    endtask

    task automatic send_command(input logic [7:0] cmd, input int n, input logic [7:0] arg2,
                                input logic [7:0] arg3, input logic [7:0] lamp_byte);
        fill_body(cmd, n, arg2, arg3, lamp_byte);
        send_frame_body(n[7:0]);
    endtask

    // Lower host valid, wait for every owed reply byte, then let a frame that draws no
    // reply finish its way through the block.
    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        while (reply_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register is written at the edge that closes the access phase with pready high.
    task automatic apb_write(input logic [fiob_pkg::APB_AW-1:0] addr,
                             input logic [31:0] wdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // Back-to-back read after a write: psel stays high, the setup phase starts again.
    task automatic apb_read_expect(input logic [fiob_pkg::APB_AW-1:0] addr,
                                   input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want)
            report_mismatch("prdata", prdata, want);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mode changes only happen with the block idle.
    task automatic write_mode(input logic [31:0] value);
        wait_drained();
        apb_write(fiob_pkg::ADDR_SD_MODE, value);
        mode_shadow = value[0];
        apb_read_expect(fiob_pkg::ADDR_SD_MODE, {31'h0, mode_shadow});
    endtask

    function automatic logic known_command(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        foreach (KNOWN_CMDS[i])
            if (KNOWN_CMDS[i] == c) hit = 1'b1;
        return hit;
    endfunction

    //------------------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------------------

    // Register writes with stray upper bits, and read-back of the mode.
    task automatic test_config_port();
        write_mode(32'hFFFF_FFFF);
        write_mode(32'hFFFF_FFFE);
        write_mode(32'h0000_0001);
        write_mode(32'h0000_0000);
    endtask

    // Every command once, each with a body just long enough for its arguments.
    task automatic test_every_command();
        int n;
        for (int k = 0; k < N_KNOWN; k++) begin
            case (KNOWN_CMDS[k])
                fiob_pkg::CMD_LAMP:                      n = 7;
                fiob_pkg::CMD_PLUG:                      n = 3;
                fiob_pkg::CMD_PORT, fiob_pkg::CMD_RMT_WR: n = 4;
                default:                                 n = 2;
            endcase
            send_command(KNOWN_CMDS[k], n, 8'h00, 8'h5A, 8'h0F);
        end
    endtask

    // Malformed writes, bodies too short for their command and escape corner cases.
    task automatic test_frame_special_cases();
        // Writes too short to carry a header are dropped.
        host_bytes = '{fiob_pkg::SOF_BYTE};
        send_host_write();
        host_bytes = '{8'h3C};
        send_host_write();
        // An empty body and a one-byte body have no command byte.
        host_bytes = '{fiob_pkg::SOF_BYTE, 8'h00};
        send_host_write();
        host_bytes = '{fiob_pkg::SOF_BYTE, 8'h01, fiob_pkg::CMD_STAT_05};
        send_host_write();
        // Wrong start byte, and a length byte above the maximum.
        host_bytes = '{8'h55, 8'h02, 8'h00, fiob_pkg::CMD_STAT_05};
        send_host_write();
        host_bytes = '{fiob_pkg::SOF_BYTE, 8'h82, 8'h00, fiob_pkg::CMD_STAT_05};
        send_host_write();
        // Decoded body shorter and longer than the length byte.
        host_bytes = '{fiob_pkg::SOF_BYTE, 8'h03, 8'h00, fiob_pkg::CMD_STAT_05};
        send_host_write();
        host_bytes = '{fiob_pkg::SOF_BYTE, 8'h02, 8'h00, fiob_pkg::CMD_STAT_05, 8'h00};
        send_host_write();
        // Unknown commands, one of them an escaped 0xFF.
        send_command(8'h00, 2, 8'h00, 8'h00, 8'h00);
        send_command(8'hFF, 4, 8'hFF, 8'hFF, 8'h00);
        // A 0xFF ending the write is a literal body byte; the remote-write reply escapes it.
        host_bytes = '{fiob_pkg::SOF_BYTE, 8'h03, 8'h00, fiob_pkg::CMD_RMT_WR,
                       fiob_pkg::ESC_BYTE};
        send_host_write();
        host_bytes = '{fiob_pkg::SOF_BYTE, 8'h04, 8'h11, fiob_pkg::CMD_PORT, 8'h00,
                       fiob_pkg::ESC_BYTE};
        send_host_write();
        // Port open, and a start byte echoed with an escape.
        send_command(fiob_pkg::CMD_PORT, 4, 8'h00, 8'h01, 8'h00);
        send_command(fiob_pkg::CMD_RMT_WR, 4, 8'h00, fiob_pkg::SOF_BYTE, 8'h00);
        // Bodies too short for the command read the missing bytes as zero.
        send_command(fiob_pkg::CMD_LAMP, 2, 8'h00, 8'h00, 8'h00);
        send_command(fiob_pkg::CMD_RMT_WR, 2, 8'h00, 8'h00, 8'h00);
        send_command(fiob_pkg::CMD_PORT, 3, 8'h00, 8'h00, 8'h00);
    endtask

    // Lamp mapping in both modes; the mode switch shows which lamps keep their state.
    task automatic test_lamp_mapping();
        for (int m = 0; m < 2; m++) begin
            write_mode(m);
            for (int i = 0; i < 2; i++)
                send_command(fiob_pkg::CMD_LAMP, 7, rand_byte(), rand_byte(),
                             LAMP_PATTERNS[2 * m + i]);
            send_command(fiob_pkg::CMD_CABINET, 2, 8'h00, 8'h00, 8'h00);
        end
        write_mode(32'h0);
    endtask

    // Both plug tables; only bit 4 of body byte 2 selects.
    task automatic test_plug_tables();
        send_command(fiob_pkg::CMD_PLUG, 3, fiob_pkg::PLUG_BLACK_MASK, 8'h00, 8'h00);
        send_command(fiob_pkg::CMD_PLUG, 3, ~fiob_pkg::PLUG_BLACK_MASK, 8'h00, 8'h00);
        send_command(fiob_pkg::CMD_PLUG, 2, 8'h00, 8'h00, 8'h00);
    endtask

    // The receiver holds off long enough for the descriptor queue to fill, so the
    // block must stall host bytes while the sender keeps offering them.
    task automatic test_output_backpressure();
        wait_drained();
        hold_left = 400;
        for (int i = 0; i < 8; i++)
            send_command(KNOWN_CMDS[$urandom_range(N_KNOWN - 1)], 2, rand_byte(),
                         rand_byte(), rand_byte());
        send_command(fiob_pkg::CMD_PLUG, 3, fiob_pkg::PLUG_BLACK_MASK, 8'h00, 8'h00);
        wait_drained();
    endtask

    // The sender stops in the middle of traffic until every reply has come.
    task automatic test_pause_until_drained();
        send_command(fiob_pkg::CMD_VERSION, 2, 8'h00, 8'h00, 8'h00);
        send_command(fiob_pkg::CMD_STAT_29, 2, 8'h00, 8'h00, 8'h00);
        wait_drained();
        send_command(fiob_pkg::CMD_RMT_RD, 2, 8'h00, 8'h00, 8'h00);
        send_command(fiob_pkg::CMD_STAT_2F, 2, 8'h00, 8'h00, 8'h00);
        wait_drained();
    endtask

    // Mostly well-formed frames of known commands with random content, the rest
    // unknown commands, length mismatches, broken headers and raw noise.
    task automatic test_random_traffic(input int n_items);
        int         start;
        int         pick;
        int         n;
        logic [7:0] cmd;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(99);
            n = ($urandom_range(15) == 0) ? $urandom_range(10, 40) : $urandom_range(2, 8);
            if (pick < 70) begin
                cmd = KNOWN_CMDS[$urandom_range(N_KNOWN - 1)];
                if (cmd == fiob_pkg::CMD_LAMP && $urandom_range(3) != 0)
                    n = $urandom_range(7, 9);
                case ($urandom_range(2))
                    0:       send_command(cmd, n, rand_byte(), 8'h00, rand_byte());
                    1:       send_command(cmd, n, rand_byte(), 8'hFF, rand_byte());
                    default: send_command(cmd, n, rand_byte(), rand_byte(), rand_byte());
                endcase
            end else if (pick < 78) begin
                cmd = rand_byte();
                while (known_command(cmd)) cmd = rand_byte();
                send_command(cmd, n, rand_byte(), rand_byte(), rand_byte());
            end else if (pick < 86) begin
                fill_body(KNOWN_CMDS[$urandom_range(N_KNOWN - 1)], n, rand_byte(),
                          rand_byte(), rand_byte());
                send_frame_body(8'(($urandom_range(1) == 0) ? n + 1 : n - 1));
            end else if (pick < 93) begin
                host_bytes.delete();
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    add_host_byte(($urandom_range(3) == 0) ? fiob_pkg::SOF_BYTE :
                                  rand_byte());
                send_host_write();
            end else begin
                fill_body(KNOWN_CMDS[$urandom_range(N_KNOWN - 1)], n, 8'h00, 8'h00, 8'h00);
                host_bytes.delete();
                if ($urandom_range(1) == 0) begin
                    add_host_byte(8'($urandom_range(8'hAB, 8'hFF)));
                    add_host_byte(n[7:0]);
                end else begin
                    add_host_byte(fiob_pkg::SOF_BYTE);
                    add_host_byte(n[7:0] | 8'h80);
                end
                foreach (body_bytes[i])
                    add_host_byte((body_bytes[i] == fiob_pkg::ESC_BYTE) ? 8'h00 :
                                  body_bytes[i]);
                send_host_write();
            end
        end
    endtask

    //------------------------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------------------------

    initial begin
        // Reset is held once, at the start of the run.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_config_port();
        test_every_command();
        test_frame_special_cases();
        test_lamp_mapping();
        test_plug_tables();
        test_output_backpressure();
        test_pause_until_drained();

        // Random traffic in both modes, with one stretch where neither side idles.
        write_mode(32'h0);
        test_random_traffic(10);
        write_mode(32'h1);
        test_random_traffic(10);
        wait_drained();
        no_idle = 1'b1;
        test_random_traffic(20);
        wait_drained();
        no_idle = 1'b0;

        // All host bytes are in; wait for the last replies and a quiet tail.
        wait_drained();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
